[hdl/omfrd_pkg.sv]
// omfrd_pkg: shared types, codes and helpers of the object record deframer
// no dependencies; imported by the parser, the top level and the testbench

package omfrd_pkg;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_BODY    = 3'd3,
    PH_STOPPED = 3'd4,
    PH_HALTED  = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    ST_PROGRESS    = 4'd0,
    ST_OK          = 4'd1,
    ST_STOPPED     = 4'd2,
    ST_NULL        = 4'd3,
    ST_EOF         = 4'd4,
    ST_CHECKSUM    = 4'd5,
    ST_TOO_LARGE   = 4'd6,
    ST_TRUNCATED   = 4'd7,
    ST_DUP_LIBHEAD = 4'd8,
    ST_HALTED      = 4'd9
  } status_e;

  localparam logic [7:0]  TYPE_LIBHEAD  = 8'hF0;
  localparam logic [7:0]  TYPE_LIBEND   = 8'hF1;
  localparam logic [7:0]  TYPE_MODEND   = 8'h8A;
  localparam logic [7:0]  MODEND_MASK   = 8'hFE;
  localparam logic [16:0] HEADER_BYTES  = 17'd3;
  localparam logic [15:0] MIN_CAPACITY  = 16'd16;
  localparam logic [15:0] RESET_CAPACITY = 16'd1024;

  typedef struct packed {
    status_e     status;
    logic [7:0]  record_type;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] payload_index;
    logic [15:0] record_length;
    logic [31:0] record_offset;
    logic [16:0] block_size;
  } result_t;

  function automatic logic ends_module(input logic [7:0] t);
    return (t == TYPE_LIBEND) || ((t & MODEND_MASK) == TYPE_MODEND);
  endfunction

endpackage

[hdl/omfrd_if.sv]
// omfrd_if: valid/ready channel interfaces for stream bytes, result words
// and the capacity register write; no dependencies

interface omfrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface omfrd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  record_type;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic [15:0] payload_index;
  logic [15:0] record_length;
  logic [31:0] record_offset;
  logic [16:0] block_size;

  modport source (output valid, output status, output record_type, output payload_byte,
                  output payload_valid, output payload_index, output record_length,
                  output record_offset, output block_size, input ready);
  modport sink   (input valid, input status, input record_type, input payload_byte,
                  input payload_valid, input payload_index, input record_length,
                  input record_offset, input block_size, output ready);
endinterface

interface omfrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/omfrd_parser.sv]
// omfrd_parser: record parse state and per-byte next-state / result logic
// depends on omfrd_pkg; the result is registered by the top level

module omfrd_parser import omfrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  input  logic [15:0] capacity_i,
  output result_t     result_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [7:0]  sum_q, sum_d;
  logic [16:0] lib_q, lib_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] start_q, start_d;

  logic [15:0] cap;
  logic [15:0] len_full;
  logic [7:0]  sum_new;
  logic        hdr_null;
  logic        too_large;
  logic        more_body;
  logic        cks_bad;
  logic        dup_lib;

  assign cap       = (capacity_i < MIN_CAPACITY) ? MIN_CAPACITY : capacity_i;
  assign len_full  = {data_byte_i, len_q[7:0]};
  assign sum_new   = sum_q + data_byte_i;
  assign hdr_null  = (type_q == 8'd0) || (len_full == 16'd0);
  assign too_large = len_full > cap;
  // seen + 1 < len, done without the overflow
  assign more_body = ({1'b0, seen_q} + 17'd1) < {1'b0, len_q};
  assign cks_bad   = (data_byte_i != 8'd0) && (sum_new != 8'd0);
  assign dup_lib   = (type_q == TYPE_LIBHEAD) && (lib_q != 17'd0);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (phase_q != PH_HALTED && phase_q != PH_STOPPED) begin
      if (end_of_input_i) begin
        phase_d = (phase_q == PH_BODY) ? PH_HALTED : PH_TYPE;
      end else begin
        case (phase_q)
          PH_TYPE:   phase_d = PH_LEN_LO;
          PH_LEN_LO: phase_d = PH_LEN_HI;
          PH_LEN_HI: begin
            if (hdr_null) phase_d = PH_TYPE;
            else if (too_large) phase_d = PH_HALTED;
            else phase_d = PH_BODY;
          end
          PH_BODY: begin
            if (more_body) phase_d = PH_BODY;
            else if (cks_bad || dup_lib) phase_d = PH_HALTED;
            else phase_d = ends_module(type_q) ? PH_STOPPED : PH_TYPE;
          end
          default: phase_d = PH_HALTED;
        endcase
      end
    end
  end

  // datapath and result word
  always_comb begin
    type_d  = type_q;
    len_d   = len_q;
    seen_d  = seen_q;
    sum_d   = sum_q;
    lib_d   = lib_q;
    pos_d   = pos_q;
    start_d = start_q;
    result_o = '0;
    result_o.status = ST_PROGRESS;
    if (phase_q == PH_HALTED) begin
      result_o.status = ST_HALTED;
    end else if (phase_q == PH_STOPPED) begin
      result_o.status = ST_STOPPED;
    end else if (end_of_input_i) begin
      result_o.status = (phase_q == PH_BODY) ? ST_TRUNCATED : ST_EOF;
    end else begin
      pos_d = pos_q + 32'd1;
      case (phase_q)
        PH_TYPE: begin
          start_d = pos_q;
          type_d  = data_byte_i;
          sum_d   = data_byte_i;
        end
        PH_LEN_LO: begin
          len_d = {8'd0, data_byte_i};
          sum_d = sum_new;
        end
        PH_LEN_HI: begin
          len_d = len_full;
          sum_d = sum_new;
          if (hdr_null) result_o.status = ST_NULL;
          else if (too_large) result_o.status = ST_TOO_LARGE;
          else seen_d = 16'd0;
        end
        default: begin
          sum_d = sum_new;
          if (more_body) begin
            result_o.payload_byte  = data_byte_i;
            result_o.payload_valid = 1'b1;
            result_o.payload_index = seen_q;
            seen_d = seen_q + 16'd1;
          end else if (cks_bad) begin
            result_o.status = ST_CHECKSUM;
          end else if (dup_lib) begin
            result_o.status = ST_DUP_LIBHEAD;
          end else begin
            if (type_q == TYPE_LIBHEAD) lib_d = {1'b0, len_q} + HEADER_BYTES;
            result_o.status        = ST_OK;
            result_o.record_length = len_q - 16'd1;
          end
        end
      endcase
    end
    result_o.record_type   = type_d;
    result_o.record_offset = start_d;
    result_o.block_size    = lib_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      type_q  <= '0;
      len_q   <= '0;
      seen_q  <= '0;
      sum_q   <= '0;
      lib_q   <= '0;
      pos_q   <= '0;
      start_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      sum_q   <= sum_d;
      lib_q   <= lib_d;
      pos_q   <= pos_d;
      start_q <= start_d;
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALTED |=> phase_q == PH_HALTED)
    else $error("left halted phase");

  a_eof_no_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_input_i |=> $stable(pos_q))
    else $error("stream position moved on end of input");

  a_body_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> seen_q < len_q)
    else $error("body byte count ran past record length");

endmodule

[hdl/omf_record_deframer.sv]
// Object record deframer. One stream byte (or an end-of-input mark) is taken per
// cycle and one result word comes out per item from an output register loaded on
// acceptance; a new byte is accepted whenever that register is empty or is being
// read in the same cycle, so while the receiver holds ready high the sustained
// rate is one item per clock with no bubbles. The parse/checksum update in
// omfrd_parser is combinational. The capacity register resets to 1024 and is
// written through cfg_i (always ready); write it only while no item is in flight.
// depends on omfrd_pkg, omfrd_if and omfrd_parser

module omf_record_deframer import omfrd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  omfrd_in_if.sink     in_i,
  omfrd_out_if.source  out_o,
  omfrd_cfg_if.sink    cfg_i
);

  logic [15:0] capacity_q;
  logic        out_valid_q;
  result_t     out_q;
  result_t     result;
  logic        accept;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  omfrd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (in_i.data_byte),
    .end_of_input_i (in_i.end_of_input),
    .capacity_i     (capacity_q),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= RESET_CAPACITY;
    end else if (cfg_i.valid) begin
      capacity_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.record_type   = out_q.record_type;
  assign out_o.payload_byte  = out_q.payload_byte;
  assign out_o.payload_valid = out_q.payload_valid;
  assign out_o.payload_index = out_q.payload_index;
  assign out_o.record_length = out_q.record_length;
  assign out_o.record_offset = out_q.record_offset;
  assign out_o.block_size    = out_q.block_size;

  // a held word must never be overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input accepted over a pending result");

  a_payload_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.payload_valid |-> out_q.status == ST_PROGRESS)
    else $error("payload word with non-progress status");

  a_length_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |-> out_q.record_length == 16'd0)
    else $error("record length reported outside record ok");

endmodule

[test/tb_top.sv]
// tb_top: self-checking testbench of omf_record_deframer; drives object-file byte
// streams, predicts every result word from its own parser model and compares them
// depends on omfrd_pkg, omfrd_if and the deframer rtl

module tb_top;
  import omfrd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_ITEMS    = 1200;
  localparam int PHASE_ITEMS     = 400;

  typedef enum {CSUM_GOOD, CSUM_ZERO, CSUM_BAD} csum_mode_e;
  typedef enum {
    END_CHECKSUM, END_TOO_LARGE, END_TRUNCATED, END_DUP_LIBHEAD,
    END_LIBEND, END_MODEND_A, END_MODEND_B
  } finish_kind_e;

  logic clk = 1'b0;
  logic rst_n;

  omfrd_in_if  in_ch ();
  omfrd_out_if out_ch ();
  omfrd_cfg_if cfg_ch ();

  omf_record_deframer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser model state, starts at the reset values
  logic [15:0] capacity_reg  = RESET_CAPACITY;
  phase_e      parse_phase   = PH_TYPE;
  logic [7:0]  cur_type      = '0;
  logic [15:0] cur_length    = '0;
  logic [15:0] content_count = '0;
  logic [7:0]  header_sum    = '0;
  logic [16:0] library_block = '0;
  logic [31:0] stream_pos    = '0;
  logic [31:0] record_start  = '0;

  result_t expected_q[$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      quiet_cycles = 0;
  int      stall_left = 0;
  int      hold_request = 0;
  bit      idle_on = 1'b1;

  function automatic logic [15:0] effective_capacity();
    return (capacity_reg < MIN_CAPACITY) ? MIN_CAPACITY : capacity_reg;
  endfunction

  function automatic result_t deframe_step(input logic [7:0] b, input logic eof);
    result_t r;
    r = '0;
    r.status = ST_PROGRESS;
    if (parse_phase == PH_HALTED) begin
      r.status = ST_HALTED;
    end else if (parse_phase == PH_STOPPED) begin
      r.status = ST_STOPPED;
    end else if (eof) begin
      if (parse_phase == PH_BODY) begin
        r.status = ST_TRUNCATED;
        parse_phase = PH_HALTED;
      end else begin
        // a partial header is dropped
        r.status = ST_EOF;
        parse_phase = PH_TYPE;
      end
    end else begin
      case (parse_phase)
        PH_TYPE: begin
          record_start = stream_pos;
          cur_type = b;
          header_sum = b;
          parse_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          cur_length = {8'h00, b};
          header_sum = header_sum + b;
          parse_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          cur_length[15:8] = b;
          header_sum = header_sum + b;
          if (cur_type == 8'h00 || cur_length == 16'h0000) begin
            r.status = ST_NULL;
            parse_phase = PH_TYPE;
          end else if (cur_length > effective_capacity()) begin
            r.status = ST_TOO_LARGE;
            parse_phase = PH_HALTED;
          end else begin
            content_count = '0;
            parse_phase = PH_BODY;
          end
        end
        default: begin
          header_sum = header_sum + b;
          if (({1'b0, content_count} + 17'd1) < {1'b0, cur_length}) begin
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
            r.payload_index = content_count;
            content_count   = content_count + 16'd1;
          end else if (b != 8'h00 && header_sum != 8'h00) begin
            r.status = ST_CHECKSUM;
            parse_phase = PH_HALTED;
          end else if (cur_type == TYPE_LIBHEAD && library_block != '0) begin
            r.status = ST_DUP_LIBHEAD;
            parse_phase = PH_HALTED;
          end else begin
            if (cur_type == TYPE_LIBHEAD) library_block = {1'b0, cur_length} + HEADER_BYTES;
            r.status = ST_OK;
            r.record_length = cur_length - 16'd1;
            if (cur_type == TYPE_LIBEND || (cur_type & MODEND_MASK) == TYPE_MODEND) begin
              parse_phase = PH_STOPPED;
            end else begin
              parse_phase = PH_TYPE;
            end
          end
        end
      endcase
      stream_pos = stream_pos + 32'd1;
    end
    r.record_type   = cur_type;
    r.record_offset = record_start;
    r.block_size    = library_block;
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // register updates, input words and result words, all sampled at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (cfg_ch.valid && cfg_ch.ready) capacity_reg = cfg_ch.data;
    if (in_ch.valid && in_ch.ready) begin
      expected_q.push_back(deframe_step(in_ch.data_byte, in_ch.end_of_input));
    end
    if (out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected, status %0d", out_ch.status);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("record_type", want.record_type, out_ch.record_type);
        check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
        check_field("payload_valid", want.payload_valid, out_ch.payload_valid);
        check_field("payload_index", want.payload_index, out_ch.payload_index);
        check_field("record_length", want.record_length, out_ch.record_length);
        check_field("record_offset", want.record_offset, out_ch.record_offset);
        check_field("block_size", want.block_size, out_ch.block_size);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result receiver: random stall bursts plus one long hold on request
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_request > 0) begin
      stall_left = hold_request - 1;
      hold_request = 0;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // valid is left high after the word is taken; the next negedge decides
  task automatic send_item(input logic [7:0] b, input logic eof);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.end_of_input <= eof;
    items_sent++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    drain_results();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] plain_type();
    logic [7:0] t;
    t = 8'($urandom_range(1, 255));
    while (t == TYPE_LIBHEAD || t == TYPE_LIBEND || (t & MODEND_MASK) == TYPE_MODEND) begin
      t = 8'($urandom_range(1, 255));
    end
    return t;
  endfunction

  // header, random content and checksum; a null header ends after three bytes
  task automatic send_record(input logic [7:0] rtype, input logic [15:0] len,
                             input csum_mode_e mode);
    logic [7:0] sum;
    logic [7:0] b;
    sum = rtype + len[7:0] + len[15:8];
    send_item(rtype, 1'b0);
    send_item(len[7:0], 1'b0);
    send_item(len[15:8], 1'b0);
    if (rtype == 8'h00 || len == 16'h0000) return;
    for (int i = 1; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      send_item(b, 1'b0);
    end
    case (mode)
      CSUM_GOOD: b = 8'h00 - sum;
      CSUM_ZERO: b = 8'h00;
      default: begin
        b = 8'h00 - sum + 8'($urandom_range(1, 254));
        if (b == 8'h00) b = 8'h01;
      end
    endcase
    send_item(b, 1'b0);
  endtask

  task automatic test_directed();
    send_item(8'hA5, 1'b1);  // end mark before any record
    send_item(8'h00, 1'b0);  // null type
    send_item(8'h05, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h12, 1'b0);  // zero length
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);  // end mark after the type byte
    send_item(8'h00, 1'b1);
    send_item(8'h80, 1'b0);  // end mark after the low length byte
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_record(8'h90, 16'd1, CSUM_GOOD);
    send_item(8'h88, 1'b0);  // content 00 ff, zero checksum skips the check
    send_item(8'h03, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h5A, 1'b1);
  endtask

  task automatic test_capacity_limits();
    logic [15:0] cap_pick;
    write_capacity(16'd0);
    send_record(plain_type(), MIN_CAPACITY, CSUM_GOOD);
    write_capacity(MIN_CAPACITY - 16'd1);
    send_record(plain_type(), MIN_CAPACITY, CSUM_ZERO);
    write_capacity(MIN_CAPACITY);
    send_record(plain_type(), MIN_CAPACITY, CSUM_GOOD);
    cap_pick = 16'($urandom_range(17, 400));
    write_capacity(cap_pick);
    send_record(plain_type(), cap_pick, CSUM_GOOD);
    write_capacity(16'hFFFF);
    send_record(plain_type(), 16'($urandom_range(256, 700)), CSUM_GOOD);
  endtask

  // the one accepted library header of the run, sets the block size
  task automatic test_library_header();
    idle_on = 1'b0;
    write_capacity(16'hFFFF);
    send_record(TYPE_LIBHEAD, 16'($urandom_range(16, 200)), CSUM_GOOD);
    idle_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int start;
    int phase_end;
    int sel;
    logic [15:0] cap_lim;
    logic [15:0] len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0: write_capacity(16'($urandom_range(0, 15)));
        1: write_capacity(MIN_CAPACITY);
        2: write_capacity(16'hFFFF);
        3: write_capacity(16'($urandom_range(17, 300)));
        default: write_capacity(16'($urandom_range(17, 65535)));
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      cap_lim = (effective_capacity() > 16'd2000) ? 16'd2000 : effective_capacity();
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        sel = $urandom_range(0, 19);
        case (sel)
          0: send_record(8'h00, 16'($urandom_range(0, 65535)), CSUM_GOOD);
          1: send_record(8'($urandom_range(0, 255)), 16'd0, CSUM_GOOD);
          2: send_item(8'($urandom_range(0, 255)), 1'b1);
          3: begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 1) == 1) send_item(8'($urandom_range(0, 255)), 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
          end
          default: begin
            sel = $urandom_range(0, 49);
            if (sel == 0) len = cap_lim;
            else if (sel == 1) len = 16'($urandom_range(1, cap_lim));
            else len = 16'($urandom_range(1, (cap_lim > 16'd24) ? 24 : cap_lim));
            send_record(plain_type(), len,
                        ($urandom_range(0, 7) == 0) ? CSUM_ZERO : CSUM_GOOD);
          end
        endcase
      end
    end
  endtask

  // receiver holds off while words keep coming, the block must stall its input
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    drain_results();
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    repeat (6) send_record(plain_type(), 16'($urandom_range(1, 12)), CSUM_GOOD);
  endtask

  // one way to end the stream per run, then more words that must change nothing
  task automatic test_stream_termination();
    finish_kind_e kind;
    logic [7:0] t;
    logic [15:0] len;
    idle_on = 1'b0;
    write_capacity(16'($urandom_range(16, 64)));
    kind = finish_kind_e'($urandom_range(0, 6));
    t = plain_type();
    len = 16'($urandom_range(2, 12));
    case (kind)
      END_CHECKSUM:    send_record(t, len, CSUM_BAD);
      END_TOO_LARGE:   send_record(t, effective_capacity() + 16'($urandom_range(1, 300)),
                                   CSUM_GOOD);
      END_TRUNCATED: begin
        send_item(t, 1'b0);
        send_item(len[7:0], 1'b0);
        send_item(len[15:8], 1'b0);
        repeat ($urandom_range(0, len - 1)) send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      END_DUP_LIBHEAD: send_record(TYPE_LIBHEAD, len, CSUM_GOOD);
      END_LIBEND:      send_record(TYPE_LIBEND, len, CSUM_GOOD);
      END_MODEND_A:    send_record(TYPE_MODEND, len, CSUM_GOOD);
      default:         send_record(TYPE_MODEND | ~MODEND_MASK, len, CSUM_ZERO);
    endcase
    repeat (3) send_record(plain_type(), 16'($urandom_range(1, 8)), CSUM_GOOD);
    repeat (20) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_input  = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    out_ch.ready        = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_capacity_limits();
    test_library_header();
    test_random_stream();
    test_output_backpressure();
    test_stream_termination();

    drain_results();
    repeat (4) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected result words never arrived", expected_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
